### src/tdsi_pkg.sv
package tdsi_pkg;

  // Field widths
  localparam int TEMP_W    = 12;
  localparam int DUTY_W    = 10;
  localparam int BLINK_W   = 8;
  localparam int TICK_W    = 16;
  localparam int RES_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  // Divider retires this many quotient bits per cycle
  localparam int DIV_STEP = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIP_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMB_THR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DUTY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DOOR_INV  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK     = 3'd6;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] HIGH_THR_RST  = 12'sd390;
  localparam logic signed [TEMP_W-1:0] TRIP_THR_RST  = 12'sd350;
  localparam logic signed [TEMP_W-1:0] AMB_THR_RST   = 12'sd300;
  localparam logic [DUTY_W-1:0]        MOD_DUTY_RST  = 10'd510;
  localparam logic [DUTY_W-1:0]        RAMP_STEP_RST = 10'd150;
  localparam logic [BLINK_W-1:0]       BLINK_RST     = 8'd3;

  // Datapath constants
  localparam logic signed [TEMP_W-1:0] AVG_RESET = 12'sd250;
  localparam logic [DUTY_W-1:0]        DUTY_MAX  = 10'd1000;

  // Button result codes
  localparam logic [RES_W-1:0] BTN_NONE       = 3'd0;
  localparam logic [RES_W-1:0] BTN_STARTED    = 3'd1;
  localparam logic [RES_W-1:0] BTN_RESET_DONE = 3'd2;
  localparam logic [RES_W-1:0] BTN_REF_DOOR   = 3'd3;
  localparam logic [RES_W-1:0] BTN_REF_TEMP   = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic upd_sample;
    logic div_start;
    logic div_sel_tick;
    logic avg_load;
    logic phase_load;
    logic mul_load;
    logic cmp_load;
    logic commit;
  } tdsi_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_free;
  } tdsi_sts_t;

endpackage

### src/tdsi_if.sv
interface tdsi_in_if import tdsi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     sample_valid;
  logic signed [TEMP_W-1:0] temp_sample;
  logic                     contact_a;
  logic                     contact_b;
  logic                     button_level;

  modport source (
    output valid, sample_valid, temp_sample, contact_a, contact_b, button_level,
    input  ready
  );
  modport sink (
    input  valid, sample_valid, temp_sample, contact_a, contact_b, button_level,
    output ready
  );
endinterface

interface tdsi_out_if import tdsi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] avg_temp;
  logic [DUTY_W-1:0]        fan_duty;
  logic                     machine_enable;
  logic                     alarm_led;
  logic                     trip_led;
  logic                     is_running;
  logic                     door_open;
  logic                     door_fault;
  logic [RES_W-1:0]         button_result;

  modport source (
    output valid, avg_temp, fan_duty, machine_enable, alarm_led, trip_led,
           is_running, door_open, door_fault, button_result,
    input  ready
  );
  modport sink (
    input  valid, avg_temp, fan_duty, machine_enable, alarm_led, trip_led,
           is_running, door_open, door_fault, button_result,
    output ready
  );
endinterface

interface tdsi_cfg_if import tdsi_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/tdsi_div.sv
module tdsi_div import tdsi_pkg::*; #(
  parameter int DIV_W = 16,
  parameter int DVS_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int STEPS   = DIV_W / DIV_STEP;
  localparam int STEP_CW = $clog2(STEPS + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_CW-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0]   quo_r, quo_nxt;
  logic [DVS_W-1:0]   dvs_r;

  logic [DVS_W-1:0]   rem_t;
  logic [DIV_W-1:0]   quo_t;
  logic [DVS_W:0]     rem_ext;

  // Restoring steps: shift a dividend bit in, subtract when it fits
  always_comb begin
    rem_t   = rem_r;
    quo_t   = quo_r;
    rem_ext = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      rem_ext = {rem_t, quo_t[DIV_W-1]};
      quo_t   = {quo_t[DIV_W-2:0], 1'b0};
      if (rem_ext >= {1'b0, dvs_r}) begin
        rem_ext  = rem_ext - {1'b0, dvs_r};
        quo_t[0] = 1'b1;
      end
      rem_t = rem_ext[DVS_W-1:0];
    end
  end

  // Sequence the iterations
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_CW'(STEPS);
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = rem_t;
      quo_nxt = quo_t;
      cnt_nxt = cnt_r - STEP_CW'(1);
      if (cnt_r == STEP_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### src/tdsi_ctrl.sv
module tdsi_ctrl import tdsi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_sample_valid,
  input  tdsi_sts_t sts,
  output logic      in_ready,
  output tdsi_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UPD    = 4'd1;
  localparam logic [3:0] S_AVG_GO = 4'd2;
  localparam logic [3:0] S_AVG_WT = 4'd3;
  localparam logic [3:0] S_TCK_GO = 4'd4;
  localparam logic [3:0] S_TCK_WT = 4'd5;
  localparam logic [3:0] S_MUL    = 4'd6;
  localparam logic [3:0] S_CMP    = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state_r, state_nxt;

  // Walk one word through sample update, divides, compares and commit
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = in_sample_valid ? S_UPD : S_TCK_GO;
        end
      end
      S_UPD: begin
        cmd.upd_sample = 1'b1;
        state_nxt      = S_AVG_GO;
      end
      S_AVG_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_AVG_WT;
      end
      S_AVG_WT: begin
        if (sts.div_done) begin
          cmd.avg_load = 1'b1;
          state_nxt    = S_TCK_GO;
        end
      end
      S_TCK_GO: begin
        cmd.div_start    = 1'b1;
        cmd.div_sel_tick = 1'b1;
        state_nxt        = S_TCK_WT;
      end
      S_TCK_WT: begin
        if (sts.div_done) begin
          cmd.phase_load = 1'b1;
          state_nxt      = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_load = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        // Hold until the output register can take the status word
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

### src/tdsi_dp.sv
module tdsi_dp import tdsi_pkg::*; #(
  parameter int WINDOW = 8,
  parameter int DIV_W  = 16,
  parameter int DVS_W  = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tdsi_cmd_t                cmd,
  output tdsi_sts_t                sts,
  // input word payload
  input  logic signed [TEMP_W-1:0] in_temp,
  input  logic                     in_contact_a,
  input  logic                     in_contact_b,
  input  logic                     in_button,
  // register writes
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_idx,
  input  logic [CFG_DAT_W-1:0]     cfg_dat,
  // shared divider
  output logic [DIV_W-1:0]         div_dividend,
  output logic [DVS_W-1:0]         div_divisor,
  input  logic                     div_done,
  input  logic [DIV_W-1:0]         div_quo,
  // status word
  tdsi_out_if.source               out_ch
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = TEMP_W + $clog2(WINDOW);
  localparam int PRD_W = TEMP_W + CNT_W + 1;

  // Registers
  logic signed [TEMP_W-1:0] high_thr_r, trip_thr_r, amb_thr_r;
  logic [DUTY_W-1:0]        mod_duty_r, ramp_step_r;
  logic                     door_inv_r;
  logic [BLINK_W-1:0]       blink_r;

  // Latched input word
  logic signed [TEMP_W-1:0] smp_r;
  logic                     ca_r, cb_r, btn_r;

  // Moving average state
  logic signed [TEMP_W-1:0] mem [WINDOW];
  logic signed [TEMP_W-1:0] rd_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [POS_W-1:0]         wpos_r;
  logic                     full_r;
  logic signed [TEMP_W-1:0] avg_r;

  // Interlock state
  logic                     run_r, run_nxt;
  logic                     stop_r, stop_nxt;
  logic                     door_r, door_nxt;
  logic                     alarm_r, alarm_nxt;
  logic [DUTY_W-1:0]        duty_r, duty_nxt;
  logic                     last_btn_r;
  logic [TICK_W-1:0]        tick_r;

  // Per word scratch
  logic                     phase_r;
  logic signed [PRD_W-1:0]  s_eff_r;
  logic signed [PRD_W-1:0]  p_trip_r, p_amb_r, p_high_r;
  logic                     ge_trip_r, gt_amb_r, ge_high_r;

  // Output register
  logic                     out_valid_r;

  // Comb helpers
  logic [CNT_W-1:0]         cnt, cnt_eff, p_inc;
  logic signed [CNT_W:0]    cnt_s;
  logic signed [SUM_W-1:0]  old_term, sum_upd;
  logic [SUM_W-1:0]         sum_mag;
  logic [TEMP_W-1:0]        q_mag;
  logic [BLINK_W-1:0]       bt;
  logic                     fault, closed, fall;
  logic [RES_W-1:0]         result;
  logic [DUTY_W-1:0]        mod_sat, target, diff;

  // Window fill count
  assign cnt     = full_r ? CNT_W'(WINDOW) : CNT_W'(wpos_r);
  assign cnt_eff = (cnt == '0) ? CNT_W'(1) : cnt;
  assign cnt_s   = $signed({1'b0, cnt_eff});

  // Running sum update: drop the oldest sample once the window is full
  assign old_term = full_r ? SUM_W'(rd_r) : '0;
  assign sum_upd  = sum_r - old_term + SUM_W'(smp_r);
  assign p_inc    = CNT_W'(wpos_r) + CNT_W'(1);

  // Divider operands: sum magnitude over count, or tick over blink period
  assign sum_mag = sum_r[SUM_W-1] ? $unsigned(-sum_r) : $unsigned(sum_r);
  assign bt      = (blink_r == '0) ? BLINK_W'(1) : blink_r;
  assign div_dividend = cmd.div_sel_tick ? DIV_W'(tick_r) : DIV_W'(sum_mag);
  assign div_divisor  = cmd.div_sel_tick ? DVS_W'(bt) : DVS_W'(cnt);
  assign q_mag        = div_quo[TEMP_W-1:0];

  // Door, trip, button and alarm latches
  always_comb begin
    fault    = (ca_r == cb_r);
    closed   = !fault && (door_inv_r ? (ca_r && !cb_r) : (!ca_r && cb_r));
    run_nxt  = run_r;
    stop_nxt = stop_r;
    door_nxt = door_r;
    result   = BTN_NONE;
    if (closed) begin
      door_nxt = 1'b0;
    end else begin
      if (!door_r && run_r && !stop_r) begin
        stop_nxt = 1'b1;
      end
      door_nxt = 1'b1;
    end
    if (run_nxt && !stop_nxt && ge_trip_r) begin
      stop_nxt = 1'b1;
    end
    fall = last_btn_r && !btn_r;
    if (fall) begin
      if (!run_nxt) begin
        if (door_nxt) begin
          result = BTN_REF_DOOR;
        end else begin
          run_nxt = 1'b1;
          result  = BTN_STARTED;
        end
      end else if (stop_nxt) begin
        if (door_nxt) begin
          result = BTN_REF_DOOR;
        end else if (gt_amb_r) begin
          result = BTN_REF_TEMP;
        end else begin
          stop_nxt = 1'b0;
          result   = BTN_RESET_DONE;
        end
      end
    end
    alarm_nxt = alarm_r;
    if (!alarm_r && ge_high_r) begin
      alarm_nxt = 1'b1;
    end else if (alarm_r && !gt_amb_r) begin
      alarm_nxt = 1'b0;
    end
  end

  // Ramp the fan duty toward its target
  always_comb begin
    mod_sat  = (mod_duty_r > DUTY_MAX) ? DUTY_MAX : mod_duty_r;
    target   = ge_trip_r ? DUTY_MAX : (ge_high_r ? mod_sat : '0);
    duty_nxt = duty_r;
    diff     = '0;
    if (duty_r < target) begin
      diff     = target - duty_r;
      duty_nxt = (diff > ramp_step_r) ? duty_r + ramp_step_r : target;
    end else if (duty_r > target) begin
      diff     = duty_r - target;
      duty_nxt = (diff > ramp_step_r) ? duty_r - ramp_step_r : target;
    end
  end

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r  <= HIGH_THR_RST;
      trip_thr_r  <= TRIP_THR_RST;
      amb_thr_r   <= AMB_THR_RST;
      mod_duty_r  <= MOD_DUTY_RST;
      ramp_step_r <= RAMP_STEP_RST;
      door_inv_r  <= 1'b0;
      blink_r     <= BLINK_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_HIGH_THR:  high_thr_r  <= $signed(cfg_dat[TEMP_W-1:0]);
        REG_TRIP_THR:  trip_thr_r  <= $signed(cfg_dat[TEMP_W-1:0]);
        REG_AMB_THR:   amb_thr_r   <= $signed(cfg_dat[TEMP_W-1:0]);
        REG_MOD_DUTY:  mod_duty_r  <= cfg_dat[DUTY_W-1:0];
        REG_RAMP_STEP: ramp_step_r <= cfg_dat[DUTY_W-1:0];
        REG_DOOR_INV:  door_inv_r  <= cfg_dat[0];
        REG_BLINK:     blink_r     <= cfg_dat[BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample window memory, read at the write pointer ahead of the update
  always_ff @(posedge clk) begin
    rd_r <= mem[wpos_r];
    if (cmd.upd_sample) begin
      mem[wpos_r] <= smp_r;
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      wpos_r      <= '0;
      full_r      <= 1'b0;
      avg_r       <= AVG_RESET;
      run_r       <= 1'b0;
      stop_r      <= 1'b0;
      door_r      <= 1'b1;
      alarm_r     <= 1'b0;
      duty_r      <= '0;
      last_btn_r  <= 1'b1;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd_sample) begin
        sum_r <= sum_upd;
        if (p_inc >= CNT_W'(WINDOW)) begin
          wpos_r <= '0;
          full_r <= 1'b1;
        end else begin
          wpos_r <= p_inc[POS_W-1:0];
        end
      end
      if (cmd.avg_load) begin
        avg_r <= sum_r[SUM_W-1] ? $signed(-q_mag) : $signed(q_mag);
      end
      if (cmd.commit) begin
        run_r      <= run_nxt;
        stop_r     <= stop_nxt;
        door_r     <= door_nxt;
        alarm_r    <= alarm_nxt;
        duty_r     <= duty_nxt;
        last_btn_r <= btn_r;
        tick_r     <= tick_r + TICK_W'(1);
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per word payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_r <= in_temp;
      ca_r  <= in_contact_a;
      cb_r  <= in_contact_b;
      btn_r <= in_button;
    end
    if (cmd.phase_load) begin
      phase_r <= div_quo[0];
    end
    if (cmd.mul_load) begin
      s_eff_r  <= (cnt == '0) ? PRD_W'(AVG_RESET) : PRD_W'(sum_r);
      p_trip_r <= trip_thr_r * cnt_s;
      p_amb_r  <= amb_thr_r * cnt_s;
      p_high_r <= high_thr_r * cnt_s;
    end
    if (cmd.cmp_load) begin
      ge_trip_r <= (s_eff_r >= p_trip_r);
      gt_amb_r  <= (s_eff_r > p_amb_r);
      ge_high_r <= (s_eff_r >= p_high_r);
    end
    if (cmd.commit) begin
      out_ch.avg_temp       <= avg_r;
      out_ch.fan_duty       <= duty_nxt;
      out_ch.machine_enable <= run_nxt && !stop_nxt;
      out_ch.alarm_led      <= alarm_nxt && !phase_r;
      out_ch.trip_led       <= stop_nxt;
      out_ch.is_running     <= run_nxt;
      out_ch.door_open      <= door_nxt;
      out_ch.door_fault     <= fault;
      out_ch.button_result  <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ch.ready;

endmodule

### src/temperature_door_safety_interlock_unit.sv
// Sequence: a word with a sample updates the window and runs the average divide, then
//   the blink divide, multiply, compare and commit; other words start at the blink divide.
// Throughput: one word at a time; the shared 4-bit-per-cycle divider runs the
//   average (sum over fill count) and the blink phase (tick over blink period) in turn.
// Reset: rst_n synchronous active low; registers take their reset values, average 250,
//   door flagged open, button released; the sample window needs no clearing.
module temperature_door_safety_interlock_unit import tdsi_pkg::*; #(
  parameter int WINDOW = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  tdsi_in_if.sink      in_ch,
  tdsi_out_if.source   out_ch,
  tdsi_cfg_if.sink     cfg_ch
);

  localparam int SUM_W = TEMP_W + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int DVS_W = (BLINK_W > CNT_W) ? BLINK_W : CNT_W;
  localparam int DMX_W = (SUM_W > TICK_W) ? SUM_W : TICK_W;
  localparam int DIV_W = ((DMX_W + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;

  tdsi_cmd_t        cmd;
  tdsi_sts_t        sts;
  logic             ctrl_ready;
  logic [DIV_W-1:0] div_dividend, div_quo;
  logic [DVS_W-1:0] div_divisor;
  logic             div_done;

  // Registers are always writable
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = ctrl_ready;

  tdsi_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_sample_valid (in_ch.sample_valid),
    .sts             (sts),
    .in_ready        (ctrl_ready),
    .cmd             (cmd)
  );

  tdsi_div #(
    .DIV_W (DIV_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  tdsi_dp #(
    .WINDOW (WINDOW),
    .DIV_W  (DIV_W),
    .DVS_W  (DVS_W)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_temp      (in_ch.temp_sample),
    .in_contact_a (in_ch.contact_a),
    .in_contact_b (in_ch.contact_b),
    .in_button    (in_ch.button_level),
    .cfg_we       (cfg_ch.valid),
    .cfg_idx      (cfg_ch.index),
    .cfg_dat      (cfg_ch.data),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quo      (div_quo),
    .out_ch       (out_ch)
  );

  // Busy once a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after accept");

  // Commit only into a free output register
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("status word overwritten");

  // Divider never finishes in the cycle after a start
  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !div_done)
    else $error("divider done too early");

  // Ramped duty and result code stay in range
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.fan_duty <= DUTY_MAX) && (out_ch.button_result <= BTN_REF_TEMP))
    else $error("status word out of range");

endmodule

### test/temperature_door_safety_interlock_unit_tb.sv
module temperature_door_safety_interlock_unit_tb import tdsi_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 8;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 140;
  localparam int WRAP_WORDS = 65560;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS = 40;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic                     sample_valid;
    logic signed [TEMP_W-1:0] temp_sample;
    logic                     contact_a;
    logic                     contact_b;
    logic                     button_level;
  } tick_word_t;

  typedef struct {
    logic signed [TEMP_W-1:0] avg_temp;
    logic [DUTY_W-1:0]        fan_duty;
    logic                     machine_enable;
    logic                     alarm_led;
    logic                     trip_led;
    logic                     is_running;
    logic                     door_open;
    logic                     door_fault;
    logic [RES_W-1:0]         button_result;
  } status_t;

  logic clk;
  logic rst_n;

  tdsi_in_if  in_if ();
  tdsi_out_if out_if ();
  tdsi_cfg_if cfg_if ();

  temperature_door_safety_interlock_unit #(.WINDOW(WIN)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Interlock image: settings
  int          cf_high, cf_trip, cf_amb;
  int unsigned cf_mod, cf_ramp, cf_inv, cf_blink;

  // Interlock image: state
  logic signed [TEMP_W-1:0] win_store [WIN];
  int          win_sum;
  int          win_pos;
  bit          win_full;
  logic signed [TEMP_W-1:0] avg_q;
  bit          run_q, stop_q, door_q, alarm_q, btn_prev;
  int unsigned duty_q;
  int unsigned tick_q;

  tick_word_t tick_pending [$];
  status_t    status_expected [$];

  // Stimulus and handshake bookkeeping
  int  mismatches = 0;
  int  words_checked = 0;
  bit  in_fire = 1'b0;
  int  gap_left = 0;
  int  burst_left = 1;
  int  gap_max = 0;
  bit  rx_throttle = 1'b0;
  logic [15:0] rdy_pat = 16'hFFFF;
  int  rdy_left = 16;
  int  walk_temp = 250;
  int  walk_base = 250;
  bit  btn_lvl = 1'b1;
  tick_word_t drv_word;
  tick_word_t seen_word;
  status_t    got_word;
  status_t    want_word;

  function automatic int rnd(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_temp(input int v);
    if (v < -400) return -400;
    if (v > 1250) return 1250;
    return v;
  endfunction

  function automatic void reset_interlock();
    cf_high  = HIGH_THR_RST;
    cf_trip  = TRIP_THR_RST;
    cf_amb   = AMB_THR_RST;
    cf_mod   = MOD_DUTY_RST;
    cf_ramp  = RAMP_STEP_RST;
    cf_inv   = 0;
    cf_blink = BLINK_RST;
    for (int i = 0; i < WIN; i++) win_store[i] = '0;
    win_sum  = 0;
    win_pos  = 0;
    win_full = 1'b0;
    avg_q    = AVG_RESET;
    run_q    = 1'b0;
    stop_q   = 1'b0;
    door_q   = 1'b1;
    alarm_q  = 1'b0;
    duty_q   = 0;
    btn_prev = 1'b1;
    tick_q   = 0;
  endfunction

  function automatic void load_setting(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DAT_W-1:0] d);
    case (idx)
      REG_HIGH_THR:  cf_high  = $signed(d[TEMP_W-1:0]);
      REG_TRIP_THR:  cf_trip  = $signed(d[TEMP_W-1:0]);
      REG_AMB_THR:   cf_amb   = $signed(d[TEMP_W-1:0]);
      REG_MOD_DUTY:  cf_mod   = d[DUTY_W-1:0];
      REG_RAMP_STEP: cf_ramp  = d[DUTY_W-1:0];
      REG_DOOR_INV:  cf_inv   = d[0];
      REG_BLINK:     cf_blink = d[BLINK_W-1:0];
      default: ;
    endcase
  endfunction

  // Exact window mean against a threshold: -1, 0 or 1
  function automatic int mean_vs(input int thr);
    int n, s, t;
    n = win_full ? WIN : win_pos;
    s = win_sum;
    if (n == 0) begin
      s = AVG_RESET;
      n = 1;
    end
    t = thr * n;
    if (s > t) return 1;
    if (s < t) return -1;
    return 0;
  endfunction

  function automatic status_t interlock_step(input tick_word_t w);
    status_t s;
    bit flt, closed, blink_on;
    logic [RES_W-1:0] res;
    int slot, cnt;
    int unsigned tgt, mduty, bper;
    res = BTN_NONE;

    // Window update and truncated average
    if (w.sample_valid) begin
      slot = win_pos % WIN;
      if (win_full) win_sum -= win_store[slot];
      win_store[slot] = w.temp_sample;
      win_sum += w.temp_sample;
      slot++;
      if (slot >= WIN) begin
        slot = 0;
        win_full = 1'b1;
      end
      win_pos = slot;
      cnt = win_full ? WIN : win_pos;
      avg_q = win_sum / cnt;
    end

    // Door contacts; an opening while running latches a stop
    flt = (w.contact_a == w.contact_b);
    closed = !flt && (cf_inv ? (w.contact_a && !w.contact_b)
                             : (!w.contact_a && w.contact_b));
    if (closed) begin
      door_q = 1'b0;
    end else begin
      if (!door_q && run_q && !stop_q) stop_q = 1'b1;
      door_q = 1'b1;
    end

    // Over-temperature trip
    if (run_q && !stop_q && mean_vs(cf_trip) >= 0) stop_q = 1'b1;

    // Falling button edge: start or reset
    if (btn_prev && !w.button_level) begin
      if (!run_q) begin
        if (door_q) res = BTN_REF_DOOR;
        else begin
          run_q = 1'b1;
          res = BTN_STARTED;
        end
      end else if (stop_q) begin
        if (door_q) res = BTN_REF_DOOR;
        else if (mean_vs(cf_amb) > 0) res = BTN_REF_TEMP;
        else begin
          stop_q = 1'b0;
          res = BTN_RESET_DONE;
        end
      end
    end
    btn_prev = w.button_level;

    // Alarm with hysteresis and blink
    if (!alarm_q && mean_vs(cf_high) >= 0) alarm_q = 1'b1;
    else if (alarm_q && mean_vs(cf_amb) <= 0) alarm_q = 1'b0;
    bper = (cf_blink != 0) ? cf_blink : 1;
    blink_on = alarm_q && (((tick_q / bper) % 2) == 0);

    // Fan target and ramp
    mduty = (cf_mod > DUTY_MAX) ? DUTY_MAX : cf_mod;
    if (mean_vs(cf_trip) >= 0) tgt = DUTY_MAX;
    else if (mean_vs(cf_high) >= 0) tgt = mduty;
    else tgt = 0;
    if (duty_q < tgt)
      duty_q = (tgt - duty_q > cf_ramp) ? duty_q + cf_ramp : tgt;
    else if (duty_q > tgt)
      duty_q = (duty_q - tgt > cf_ramp) ? duty_q - cf_ramp : tgt;

    tick_q = (tick_q + 1) & 32'hFFFF;

    s.avg_temp       = avg_q;
    s.fan_duty       = duty_q[DUTY_W-1:0];
    s.machine_enable = run_q && !stop_q;
    s.alarm_led      = blink_on;
    s.trip_led       = stop_q;
    s.is_running     = run_q;
    s.door_open      = door_q;
    s.door_fault     = flt;
    s.button_result  = res;
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s got %0d want %0d",
                                words_checked, name, got, want));
  endtask

  function automatic void push_word(input bit sv, input int temp, input bit a,
                                    input bit b, input bit btn);
    tick_word_t w;
    w.sample_valid = sv;
    w.temp_sample  = temp;
    w.contact_a    = a;
    w.contact_b    = b;
    w.button_level = btn;
    tick_pending.push_back(w);
  endfunction

  // Mostly closed door, button toggling, temperature walking near the thresholds
  function automatic tick_word_t next_word();
    tick_word_t w;
    int pick;
    if (rnd(0, 9) == 0) begin
      w.sample_valid = $urandom_range(1);
      w.temp_sample  = rnd(-400, 1250);
      w.contact_a    = $urandom_range(1);
      w.contact_b    = $urandom_range(1);
      w.button_level = $urandom_range(1);
    end else begin
      if (rnd(0, 24) == 0) walk_temp = clamp_temp(walk_base + rnd(-200, 200));
      else walk_temp = clamp_temp(walk_temp + rnd(-40, 40));
      w.sample_valid = (rnd(0, 9) < 7);
      w.temp_sample  = w.sample_valid ? walk_temp : rnd(-400, 1250);
      pick = rnd(0, 99);
      if (pick < 85) begin
        w.contact_a = cf_inv[0];
        w.contact_b = !cf_inv[0];
      end else if (pick < 93) begin
        w.contact_a = !cf_inv[0];
        w.contact_b = cf_inv[0];
      end else begin
        w.contact_a = $urandom_range(1);
        w.contact_b = w.contact_a;
      end
      if (rnd(0, 3) == 0) btn_lvl = !btn_lvl;
      w.button_level = btn_lvl;
    end
    return w;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] d);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    load_setting(idx, d);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (tick_pending.size() != 0 || status_expected.size() != 0 || in_if.valid)
      @(posedge clk);
  endtask

  // Settings for one phase: low extremes, high extremes, masked writes, or random
  task automatic configure_phase(input int kind);
    int base, hi, tr, am;
    int unsigned md, rs, inv, bl;
    base = rnd(-100, 600);
    hi = clamp_temp(base + rnd(-80, 80));
    tr = clamp_temp(base + rnd(-80, 80));
    am = clamp_temp(base - rnd(0, 150));
    md = $urandom_range(1023);
    rs = (rnd(0, 4) == 0) ? $urandom_range(1023) : rnd(1, 200);
    inv = $urandom_range(1);
    bl = (rnd(0, 3) == 0) ? $urandom_range(255) : rnd(1, 6);
    if (kind > 2 && rnd(0, 3) == 0) begin
      hi = rnd(-400, 1250);
      tr = rnd(-400, 1250);
      am = rnd(-400, 1250);
    end
    case (kind)
      0: begin
        hi = -400; tr = -400; am = -400; md = 0; rs = 1; inv = 0; bl = 1;
      end
      1: begin
        hi = 1250; tr = 1250; am = 1250; md = 1000; rs = 1000; inv = 1; bl = 255;
      end
      default: ;
    endcase
    cfg_write(REG_HIGH_THR, hi);
    cfg_write(REG_TRIP_THR, tr);
    cfg_write(REG_AMB_THR, am);
    if (kind == 2) begin
      // Oversized values get masked; zero ramp and zero blink fall out of the mask
      cfg_write(REG_MOD_DUTY, 12'hFFF);
      cfg_write(REG_RAMP_STEP, 12'hC00);
      cfg_write(REG_DOOR_INV, 12'hFFE);
      cfg_write(REG_BLINK, 12'hF00);
      cfg_write(REG_SPARE, $urandom_range(4095));
    end else begin
      cfg_write(REG_MOD_DUTY, md);
      cfg_write(REG_RAMP_STEP, rs);
      cfg_write(REG_DOOR_INV, inv);
      cfg_write(REG_BLINK, bl);
    end
    walk_base = (kind < 2) ? rnd(-400, 1250) : base;
    walk_temp = walk_base;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  // Sender: bursts of words with random gaps between them
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (tick_pending.size() > 0) begin
        drv_word = tick_pending.pop_front();
        in_if.valid        <= 1'b1;
        in_if.sample_valid <= drv_word.sample_valid;
        in_if.temp_sample  <= drv_word.temp_sample;
        in_if.contact_a    <= drv_word.contact_a;
        in_if.contact_b    <= drv_word.contact_b;
        in_if.button_level <= drv_word.button_level;
        if (burst_left <= 1) begin
          burst_left = rnd(1, 16);
          gap_left = (gap_max == 0) ? 0 : rnd(0, gap_max);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall on a rotating pattern that is reloaded when its countdown runs out
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rx_throttle ? rdy_pat[0] : 1'b1;
      rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
      if (rdy_left == 0) begin
        rdy_left = 16;
        rdy_pat = (rnd(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
      end else begin
        rdy_left--;
      end
    end
  end

  // Check each status word, then predict for each accepted tick word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (status_expected.size() == 0) begin
          report_mismatch($sformatf("status word %0d with nothing pending", words_checked));
        end else begin
          want_word = status_expected.pop_front();
          got_word.avg_temp       = out_if.avg_temp;
          got_word.fan_duty       = out_if.fan_duty;
          got_word.machine_enable = out_if.machine_enable;
          got_word.alarm_led      = out_if.alarm_led;
          got_word.trip_led       = out_if.trip_led;
          got_word.is_running     = out_if.is_running;
          got_word.door_open      = out_if.door_open;
          got_word.door_fault     = out_if.door_fault;
          got_word.button_result  = out_if.button_result;
          check_field("avg_temp", got_word.avg_temp, want_word.avg_temp);
          check_field("fan_duty", got_word.fan_duty, want_word.fan_duty);
          check_field("machine_enable", got_word.machine_enable, want_word.machine_enable);
          check_field("alarm_led", got_word.alarm_led, want_word.alarm_led);
          check_field("trip_led", got_word.trip_led, want_word.trip_led);
          check_field("is_running", got_word.is_running, want_word.is_running);
          check_field("door_open", got_word.door_open, want_word.door_open);
          check_field("door_fault", got_word.door_fault, want_word.door_fault);
          check_field("button_result", got_word.button_result, want_word.button_result);
        end
        words_checked++;
      end
      in_fire <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        seen_word.sample_valid = in_if.sample_valid;
        seen_word.temp_sample  = in_if.temp_sample;
        seen_word.contact_a    = in_if.contact_a;
        seen_word.contact_b    = in_if.contact_b;
        seen_word.button_level = in_if.button_level;
        status_expected.push_back(interlock_step(seen_word));
      end
    end
  end

  initial begin
    tick_word_t w;
    reset_interlock();
    rst_n = 1'b0;
    in_if.valid        = 1'b0;
    in_if.sample_valid = 1'b0;
    in_if.temp_sample  = '0;
    in_if.contact_a    = 1'b0;
    in_if.contact_b    = 1'b0;
    in_if.button_level = 1'b1;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: refusals, start, idle press, door trip, resets, window wrap
    gap_max = 3;
    rx_throttle = 1'b1;
    push_word(1, -400, 0, 0, 0);
    push_word(0, rnd(-400, 1250), 1, 1, 1);
    push_word(1, -400, 0, 1, 1);
    push_word(0, rnd(-400, 1250), 0, 1, 0);
    push_word(0, rnd(-400, 1250), 0, 1, 1);
    push_word(0, rnd(-400, 1250), 0, 1, 0);
    push_word(0, rnd(-400, 1250), 1, 0, 1);
    push_word(0, rnd(-400, 1250), 0, 1, 0);
    for (int i = 0; i < 6; i++) push_word(1, 1250, 0, 1, 1);
    push_word(0, rnd(-400, 1250), 0, 1, 0);
    push_word(0, rnd(-400, 1250), 0, 1, 1);
    for (int i = 0; i < 6; i++) push_word(1, -400, 0, 1, 1);
    push_word(0, rnd(-400, 1250), 0, 1, 0);
    push_word(1, 0, 0, 1, 1);
    wait_idle();

    // Run the tick counter through its wrap with the alarm latched
    gap_max = 0;
    rx_throttle = 1'b0;
    for (int i = 0; i < WIN; i++) push_word(1, 1250, 0, 1, 1);
    for (int i = 0; i < WRAP_WORDS; i++) begin
      w = next_word();
      w.sample_valid = 1'b0;
      tick_pending.push_back(w);
    end
    wait_idle();

    // Random phases under changing settings and idling
    for (int ph = 0; ph < PHASES; ph++) begin
      configure_phase(ph);
      gap_max = (ph == 3) ? 0 : rnd(0, 12);
      rx_throttle = (ph == 3) ? 1'b0 : (rnd(0, 3) != 0);
      for (int i = 0; i < PHASE_WORDS; i++) tick_pending.push_back(next_word());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && status_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
